### design/round_robin_thread_scheduler_defines.svh
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_defines
// assertion macros shared by the scheduler's checking code
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// implication checked on every rising edge outside reset
`define RRTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrts check failed");

// next-cycle implication
`define RRTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrts check failed");

`endif

### design/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// shared types and constants of the round robin thread scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned THREADS_DEF = 8;
  localparam int unsigned WAITERS_DEF = 4;
  localparam int unsigned SEMAS_DEF   = 4;

  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_ADD    = 3'd1;
  localparam logic [2:0] FN_KILL   = 3'd2;
  localparam logic [2:0] FN_SLEEP  = 3'd3;
  localparam logic [2:0] FN_YIELD  = 3'd4;
  localparam logic [2:0] FN_WAIT   = 3'd5;
  localparam logic [2:0] FN_SIGNAL = 3'd6;
  localparam logic [2:0] FN_INIT   = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_NO_RUN  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic exec;      // apply the event's immediate effects
    logic scan_clr;  // start a scan at the slot after the running one
    logic scan_step; // look at one slot
    logic set_nrun;  // record no runnable thread
  } rrts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan; // the event switches threads
    logic scan_hit;  // current slot is runnable
    logic scan_last; // current slot is the final candidate
  } rrts_sts_t;

endpackage

### design/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// sequencer: capture, execute, round-robin scan when the event switches threads, then present the result
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output rrts_pkg::rrts_cmd_t cmd,
  input  rrts_pkg::rrts_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_scan) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (sts.scan_last) begin
          cmd.set_nrun  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/rrts_dp.sv
// ----------------------------------------------------------------------------
// rrts_dp
// thread table, semaphores and waiter rings with a one-slot-a-cycle scan
// ----------------------------------------------------------------------------
module rrts_dp #(
  parameter int unsigned THREADS = rrts_pkg::THREADS_DEF,
  parameter int unsigned WAITERS = rrts_pkg::WAITERS_DEF,
  parameter int unsigned SEMAS   = rrts_pkg::SEMAS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrts_pkg::rrts_cmd_t cmd,
  output rrts_pkg::rrts_sts_t sts,
  input  logic [2:0]          in_func,
  input  logic [1:0]          in_sema_index,
  input  logic [15:0]         in_sleep_ticks,
  input  logic signed [15:0]  in_init_value,
  output logic [2:0]          out_running_id,
  output logic [1:0]          out_status,
  output logic [2:0]          out_added_id,
  output logic signed [15:0]  out_sema_count
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int WW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int SW = (SEMAS > 1) ? $clog2(SEMAS) : 1;
  localparam logic signed [15:0] SC_MAX = 16'sh7fff;
  localparam logic signed [15:0] SC_MIN = 16'sh8000;

  logic [2:0]  func_r;
  logic [1:0]  sidx_r;
  logic [15:0] ticks_r;
  logic [15:0] ival_r;

  logic [THREADS-1:0]  active_r, blocked_r;
  logic [15:0]         sleep_r [THREADS];
  logic [TW-1:0]       run_r, cand_r;
  logic [TW:0]         cnt_r;
  logic [1:0]          status_r;
  logic [2:0]          added_r;
  logic signed [15:0]  sema_r [SEMAS];
  logic [WW-1:0]       put_r [SEMAS];
  logic [WW-1:0]       get_r [SEMAS];
  logic [WAITERS-1:0]  wvalid_r [SEMAS];
  logic [TW-1:0]       wthr_r [SEMAS][WAITERS];

  logic           sok;
  logic [SW-1:0]  s;
  logic           free_found;
  logic [TW-1:0]  free_idx;
  logic           wait_blk;
  logic           sig_wake;
  logic [TW-1:0]  cand_inc, run_inc;

  assign sok = ({3'd0, sidx_r} < 5'(SEMAS));
  assign s   = SW'(sidx_r);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = THREADS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = TW'(i);
      end
    end
  end

  assign wait_blk = sok && (sema_r[s] == 16'sd0) && !wvalid_r[s][put_r[s]];
  assign sig_wake = sok && wvalid_r[s][get_r[s]];

  assign cand_inc = (32'(cand_r) == THREADS - 1) ? '0 : cand_r + 1'b1;
  assign run_inc  = (32'(run_r) == THREADS - 1) ? '0 : run_r + 1'b1;

  assign sts.need_scan = (func_r == rrts_pkg::FN_KILL) || (func_r == rrts_pkg::FN_SLEEP) ||
                         (func_r == rrts_pkg::FN_YIELD) ||
                         ((func_r == rrts_pkg::FN_WAIT) && wait_blk);
  assign sts.scan_hit  = active_r[cand_r] && !blocked_r[cand_r] && (sleep_r[cand_r] == 16'd0);
  assign sts.scan_last = (32'(cnt_r) == THREADS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      blocked_r <= '0;
      run_r     <= '0;
      cand_r    <= '0;
      cnt_r     <= '0;
      status_r  <= rrts_pkg::ST_OK;
      added_r   <= '0;
      for (int i = 0; i < THREADS; i++) sleep_r[i] <= '0;
      for (int j = 0; j < SEMAS; j++) begin
        sema_r[j]   <= '0;
        put_r[j]    <= '0;
        get_r[j]    <= '0;
        wvalid_r[j] <= '0;
      end
    end else begin
      if (cmd.load) begin
        func_r   <= in_func;
        sidx_r   <= in_sema_index;
        ticks_r  <= in_sleep_ticks;
        ival_r   <= in_init_value;
        status_r <= rrts_pkg::ST_OK;
        added_r  <= '0;
      end
      if (cmd.exec) begin
        case (func_r)
          rrts_pkg::FN_TICK: begin
            for (int i = 0; i < THREADS; i++)
              if (sleep_r[i] != 16'd0) sleep_r[i] <= sleep_r[i] - 16'd1;
          end
          rrts_pkg::FN_ADD: begin
            if (free_found) begin
              active_r[free_idx]  <= 1'b1;
              blocked_r[free_idx] <= 1'b0;
              added_r             <= 3'(free_idx);
            end else begin
              status_r <= rrts_pkg::ST_NO_SLOT;
            end
          end
          rrts_pkg::FN_KILL:  active_r[run_r] <= 1'b0;
          rrts_pkg::FN_SLEEP: sleep_r[run_r]  <= ticks_r;
          rrts_pkg::FN_WAIT: begin
            if (wait_blk) begin
              blocked_r[run_r]          <= 1'b1;
              wthr_r[s][put_r[s]]       <= run_r;
              wvalid_r[s][put_r[s]]     <= 1'b1;
              put_r[s]                  <= (32'(put_r[s]) == WAITERS - 1) ? '0 : put_r[s] + 1'b1;
            end else if (sok && sema_r[s] != SC_MIN) begin
              sema_r[s] <= sema_r[s] - 16'sd1;
            end
          end
          rrts_pkg::FN_SIGNAL: begin
            if (sig_wake) begin
              blocked_r[wthr_r[s][get_r[s]]] <= 1'b0;
              wvalid_r[s][get_r[s]]          <= 1'b0;
              get_r[s] <= (32'(get_r[s]) == WAITERS - 1) ? '0 : get_r[s] + 1'b1;
            end else if (sok && sema_r[s] != SC_MAX) begin
              sema_r[s] <= sema_r[s] + 16'sd1;
            end
          end
          rrts_pkg::FN_INIT: begin
            if (sok) begin
              sema_r[s]   <= ival_r;
              put_r[s]    <= '0;
              get_r[s]    <= '0;
              wvalid_r[s] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan_clr) begin
        cand_r <= run_inc;
        cnt_r  <= '0;
      end
      if (cmd.scan_step) begin
        if (sts.scan_hit) run_r <= cand_r;
        cand_r <= cand_inc;
        cnt_r  <= cnt_r + 1'b1;
      end
      if (cmd.set_nrun) status_r <= rrts_pkg::ST_NO_RUN;
    end
  end

  assign out_running_id = 3'(run_r);
  assign out_status     = status_r;
  assign out_added_id   = added_r;
  assign out_sema_count = sok ? sema_r[s] : 16'sd0;

endmodule

### design/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// thread scheduler with round-robin switching and counting semaphores
// ----------------------------------------------------------------------------
//  channel  direction  handshake             fields
//  in_      input      in_valid / in_stall   func, sema_index, sleep_ticks, init_value
//  out_     output     out_valid / out_stall running_id, status, added_id, sema_count
//
//  an item is captured, executed and, in a switch, scanned over up to THREADS slots,
//  the scan steps through one thread slot a cycle
//  a new item is taken once the previous result has been handed over
//  synchronous active-low reset clears thread and semaphore state; waiter slots are marked empty
//  out_stall holds the result registers steady
// ----------------------------------------------------------------------------
`include "round_robin_thread_scheduler_defines.svh"

module round_robin_thread_scheduler #(
  parameter int unsigned THREADS = rrts_pkg::THREADS_DEF,
  parameter int unsigned WAITERS = rrts_pkg::WAITERS_DEF,
  parameter int unsigned SEMAS   = rrts_pkg::SEMAS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [1:0]         in_sema_index,
  input  logic [15:0]        in_sleep_ticks,
  input  logic signed [15:0] in_init_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_running_id,
  output logic [1:0]         out_status,
  output logic [2:0]         out_added_id,
  output logic signed [15:0] out_sema_count
);

  // command and status between sequencer and datapath
  rrts_pkg::rrts_cmd_t cmd;
  rrts_pkg::rrts_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rrts_dp #(
    .THREADS (THREADS),
    .WAITERS (WAITERS),
    .SEMAS   (SEMAS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_sema_index  (in_sema_index),
    .in_sleep_ticks (in_sleep_ticks),
    .in_init_value  (in_init_value),
    .out_running_id (out_running_id),
    .out_status     (out_status),
    .out_added_id   (out_added_id),
    .out_sema_count (out_sema_count)
  );

  // no new item while a result is pending
  `RRTS_ASSERT_IMP(a_busy_stall, out_valid, in_stall)
  // a held result stays put
  `RRTS_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_running_id) && $stable(out_status))
  // status is never the reserved code
  `RRTS_ASSERT_IMP(a_status, out_valid, out_status != 2'd3)

endmodule
